[design/is_pkg.sv]
package is_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  // Commands from the controller to the datapath. At most one command
  // is asked for in a cycle.
  typedef struct packed {
    logic capture;     // latch the incoming request and start at the fill count
    logic set_drop;    // store is full, remember that a value was lost
    logic rd_prev;     // read the entry just below the insert position
    logic shift;       // move the entry read last cycle up one place
    logic place;       // write the new value at the insert position
    logic emit_start;  // read the first entry of the run
    logic emit_rd;     // read the next entry of the run
    logic run_clear;   // end of run, empty the store
  } is_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic greater;
    logic emit_last;
    logic last_item;
  } is_sts_t;

endpackage

[design/is_if.sv]
interface is_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [is_pkg::DATA_W-1:0]  value;
  logic                              last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface is_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [is_pkg::DATA_W-1:0]  sorted_value;
  logic                              last_out;
  logic                              overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

[design/is_ctrl.sv]
module is_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  is_pkg::is_sts_t sts,
  output is_pkg::is_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_EBEGIN = 3'd3;
  localparam logic [2:0] S_SHOW   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SHOW);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_INS;
        end
      end
      S_INS: begin
        if (sts.full) begin
          cmd.set_drop = 1'b1;
          state_next   = sts.last_item ? S_EBEGIN : S_IDLE;
        end else if (sts.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = sts.last_item ? S_EBEGIN : S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.pos_zero || !sts.greater) begin
          cmd.place  = 1'b1;
          state_next = sts.last_item ? S_EBEGIN : S_IDLE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_EBEGIN: begin
        cmd.emit_start = 1'b1;
        state_next     = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.run_clear = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.emit_rd = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/is_dpath.sv]
module is_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  is_pkg::is_cmd_t                  cmd,
  output is_pkg::is_sts_t                  sts,
  input  logic signed [is_pkg::DATA_W-1:0] value,
  input  logic                             last_in,
  output logic signed [is_pkg::DATA_W-1:0] sorted_value,
  output logic                             last_out,
  output logic                             overflow
);

  logic signed [is_pkg::DATA_W-1:0] mem [is_pkg::MAX_ELEMENTS];
  logic signed [is_pkg::DATA_W-1:0] rd_data;
  logic signed [is_pkg::DATA_W-1:0] value_q;
  logic                             last_q;
  logic [is_pkg::CNT_W-1:0]         pos;
  logic [is_pkg::CNT_W-1:0]         fill;
  logic                             dropped;
  logic [is_pkg::IDX_W-1:0]         emit_idx;

  logic [is_pkg::CNT_W-1:0]         pos_m1;
  logic [is_pkg::CNT_W-1:0]         pos_m2;
  logic [is_pkg::CNT_W-1:0]         fill_m1;
  logic                             ren;
  logic [is_pkg::IDX_W-1:0]         raddr;
  logic                             emit_last;

  assign pos_m1    = pos - is_pkg::CNT_W'(1);
  assign pos_m2    = pos - is_pkg::CNT_W'(2);
  assign fill_m1   = fill - is_pkg::CNT_W'(1);
  assign emit_last = ({1'b0, emit_idx} == fill_m1);

  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    if (cmd.rd_prev) begin
      ren   = 1'b1;
      raddr = pos_m1[is_pkg::IDX_W-1:0];
    end else if (cmd.shift) begin
      // Fetch the next candidate while the current one moves up.
      ren   = 1'b1;
      raddr = pos_m2[is_pkg::IDX_W-1:0];
    end else if (cmd.emit_start) begin
      ren   = 1'b1;
      raddr = '0;
    end else if (cmd.emit_rd) begin
      ren   = 1'b1;
      raddr = emit_idx + is_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rd_data <= mem[raddr];
    end
    if (cmd.shift) begin
      mem[pos[is_pkg::IDX_W-1:0]] <= rd_data;
    end else if (cmd.place) begin
      mem[pos[is_pkg::IDX_W-1:0]] <= value_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_q <= value;
      last_q  <= last_in;
      pos     <= fill;
    end else if (cmd.shift) begin
      pos <= pos_m1;
    end
    if (cmd.emit_start) begin
      emit_idx <= '0;
    end else if (cmd.emit_rd) begin
      emit_idx <= emit_idx + is_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.run_clear) begin
        fill    <= '0;
        dropped <= 1'b0;
      end else begin
        if (cmd.place) begin
          fill <= fill + is_pkg::CNT_W'(1);
        end
        if (cmd.set_drop) begin
          dropped <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.full      = (fill == is_pkg::CNT_W'(is_pkg::MAX_ELEMENTS));
    sts.pos_zero  = (pos == '0);
    sts.greater   = (rd_data > value_q);
    sts.emit_last = emit_last;
    sts.last_item = last_q;
  end

  assign sorted_value = rd_data;
  assign last_out     = emit_last;
  assign overflow     = dropped;

endmodule

[design/insertion_sorter_top.sv]
// Streaming insertion sorter for signed 32-bit values. A run of values
// arrives on the items channel, one per request, with last_in set on the
// final request of the run. Each value is inserted into a 64-entry sorted
// store held in a single-port-write, single-port-read memory: entries larger
// than the new value move up one place, one entry per clock cycle, so equal
// values keep their arrival order. A request is taken only while the block
// is idle. The first value of a run goes straight into the empty store;
// the time any later value occupies the block grows with the number of
// larger entries it passes over, set by the one-entry-per-cycle shift
// loop through the memory's single write port. Once the final value is
// placed or dropped, the S_EBEGIN state fetches the smallest entry and
// the run is then sent on the results channel in ascending order at one
// result per cycle while the receiver is ready, with last_out on the
// final result. A run longer than 64 values keeps its first 64 values,
// drops the rest and reports overflow on every result of that run. The
// store needs no clearing after reset: only entries below the fill count
// ever reach a comparison or the output.
module insertion_sorter_top (
  input  logic      clk,
  input  logic      rst,
  is_in_if.sink     items,
  is_out_if.source  results
);

  // Command and status bundles between the sequencer and the datapath.
  is_pkg::is_cmd_t cmd;
  is_pkg::is_sts_t sts;

  // The controller owns both handshakes: it takes a request only when idle
  // and presents a result only in its output state, where the datapath's
  // registered read port holds the entry being offered.
  is_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the sorted store, the fill count, the overflow flag
  // and the insert and output pointers.
  is_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (items.value),
    .last_in      (items.last_in),
    .sorted_value (results.sorted_value),
    .last_out     (results.last_out),
    .overflow     (results.overflow)
  );

endmodule

[design/is_checker.sv]
module is_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [is_pkg::DATA_W-1:0] sorted_value,
  input logic                             last_out,
  input logic                             overflow
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_value) &&
                                $stable(last_out) && $stable(overflow))
    else $error("stalled result changed");

  // No request is taken while a run is being sent.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && out_valid))
    else $error("request accepted during output");

  // A run's output continues without a gap until its last result.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_out |=> out_valid)
    else $error("gap inside output run");

  // Results of a run come out in ascending order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_out |=> sorted_value >= $past(sorted_value))
    else $error("results out of order");

  // After the last result the block goes back to taking requests.
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> !out_valid && in_ready)
    else $error("block did not return to idle after a run");

endmodule

bind insertion_sorter_top is_checker u_is_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .sorted_value (results.sorted_value),
  .last_out     (results.last_out),
  .overflow     (results.overflow)
);
